FILE: rtl/core/word_alu_with_excess_register_top_macros.svh
// Assertion macros for the word ALU with excess register.
// Included by the modules that carry concurrent assertions.
`ifndef WORD_ALU_WITH_EXCESS_REGISTER_TOP_MACROS_SVH
`define WORD_ALU_WITH_EXCESS_REGISTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define WAE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("word ALU assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define WAE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("word ALU assertion failed");

`endif

FILE: rtl/core/wae_pkg.sv
// Shared types and constants of the word ALU with excess register.
// Used by wae_alu, wae_div and the top level; depends on nothing.
package wae_pkg;

	localparam int WORD_W = 16;
	localparam int DIV_ITERS = WORD_W;
	localparam int MOD_ITERS = WORD_W / 2;
	localparam int CNT_W = $clog2(DIV_ITERS);

	localparam logic [4:0] MODE_SET = 5'd0;
	localparam logic [4:0] MODE_ADD = 5'd1;
	localparam logic [4:0] MODE_SUB = 5'd2;
	localparam logic [4:0] MODE_MUL = 5'd3;
	localparam logic [4:0] MODE_MLI = 5'd4;
	localparam logic [4:0] MODE_DIV = 5'd5;
	localparam logic [4:0] MODE_DVI = 5'd6;
	localparam logic [4:0] MODE_MOD = 5'd7;
	localparam logic [4:0] MODE_MDI = 5'd8;
	localparam logic [4:0] MODE_AND = 5'd9;
	localparam logic [4:0] MODE_BOR = 5'd10;
	localparam logic [4:0] MODE_XOR = 5'd11;
	localparam logic [4:0] MODE_SHR = 5'd12;
	localparam logic [4:0] MODE_ASR = 5'd13;
	localparam logic [4:0] MODE_SHL = 5'd14;
	localparam logic [4:0] MODE_IFB = 5'd15;
	localparam logic [4:0] MODE_IFC = 5'd16;
	localparam logic [4:0] MODE_IFE = 5'd17;
	localparam logic [4:0] MODE_IFN = 5'd18;
	localparam logic [4:0] MODE_IFG = 5'd19;
	localparam logic [4:0] MODE_IFA = 5'd20;
	localparam logic [4:0] MODE_IFL = 5'd21;
	localparam logic [4:0] MODE_IFU = 5'd22;
	localparam logic [4:0] MODE_ADX = 5'd23;
	localparam logic [4:0] MODE_SBX = 5'd24;

	localparam logic [WORD_W-1:0] EX_CARRY = 16'h0001;
	localparam logic [WORD_W-1:0] EX_BORROW = 16'hffff;

	typedef struct packed {
		logic [WORD_W-1:0] res;
		logic              wb;
		logic              skip;
		logic [WORD_W-1:0] ex;
	} alu_res_t;

	typedef struct packed {
		logic start;
		logic is_signed;
		logic is_mod;
	} div_ctl_t;

endpackage

FILE: rtl/core/wae_alu.sv
// Combinational operations of the word ALU: set, add, subtract, logic, multiply, shifts and tests.
// Depends on wae_pkg; divide and modulo by a nonzero operand go to wae_div.
module wae_alu (
	input  logic [4:0]                 mode,
	input  logic [wae_pkg::WORD_W-1:0] a_value,
	input  logic [wae_pkg::WORD_W-1:0] b_value,
	input  logic [wae_pkg::WORD_W-1:0] ex_in,
	output wae_pkg::alu_res_t          result
);

	logic [16:0] add_t;
	logic [17:0] adx_t;
	logic signed [18:0] sbx_t;
	logic [31:0] mul_u;
	logic signed [31:0] mul_s;
	logic        sh_ok;
	logic [31:0] shr_t;
	logic [31:0] shl_t;
	logic [15:0] asr_t;
	logic        sgt;
	logic        slt;

	assign add_t = {1'b0, b_value} + {1'b0, a_value};
	assign adx_t = {2'b0, b_value} + {2'b0, a_value} + {2'b0, ex_in};
	assign sbx_t = $signed({3'b0, b_value}) - $signed({3'b0, a_value})
		+ $signed({3'b0, ex_in});
	assign mul_u = {16'h0, b_value} * {16'h0, a_value};
	assign mul_s = $signed(b_value) * $signed(a_value);
	assign sh_ok = (a_value[15:5] == 11'd0);
	assign shr_t = sh_ok ? ({b_value, 16'h0} >> a_value[4:0]) : 32'd0;
	assign shl_t = sh_ok ? ({16'h0, b_value} << a_value[4:0]) : 32'd0;
	assign asr_t = (a_value[15:4] != 12'd0) ? {16{b_value[15]}}
		: 16'($signed(b_value) >>> a_value[3:0]);
	assign sgt = $signed(b_value) > $signed(a_value);
	assign slt = $signed(b_value) < $signed(a_value);

	always_comb begin
		result.res = b_value;
		result.wb = 1'b1;
		result.skip = 1'b0;
		result.ex = ex_in;
		case (mode)
			wae_pkg::MODE_SET: begin
				result.res = a_value;
			end
			wae_pkg::MODE_ADD: begin
				result.res = add_t[15:0];
				result.ex = add_t[16] ? wae_pkg::EX_CARRY : 16'h0;
			end
			wae_pkg::MODE_SUB: begin
				result.res = b_value - a_value;
				result.ex = (a_value > b_value) ? wae_pkg::EX_BORROW : 16'h0;
			end
			wae_pkg::MODE_MUL: begin
				result.res = mul_u[15:0];
				result.ex = mul_u[31:16];
			end
			wae_pkg::MODE_MLI: begin
				result.res = mul_s[15:0];
				result.ex = mul_s[31:16];
			end
			wae_pkg::MODE_DIV, wae_pkg::MODE_DVI, wae_pkg::MODE_MOD, wae_pkg::MODE_MDI: begin
				// Only reached for a zero divisor.
				result.res = 16'h0;
				result.ex = 16'h0;
			end
			wae_pkg::MODE_AND: result.res = b_value & a_value;
			wae_pkg::MODE_BOR: result.res = b_value | a_value;
			wae_pkg::MODE_XOR: result.res = b_value ^ a_value;
			wae_pkg::MODE_SHR: begin
				result.res = shr_t[31:16];
				result.ex = shr_t[15:0];
			end
			wae_pkg::MODE_ASR: begin
				result.res = asr_t;
				result.ex = shr_t[15:0];
			end
			wae_pkg::MODE_SHL: begin
				result.res = shl_t[15:0];
				result.ex = shl_t[31:16];
			end
			wae_pkg::MODE_IFB: begin
				result.wb = 1'b0;
				result.skip = ((b_value & a_value) == 16'h0);
			end
			wae_pkg::MODE_IFC: begin
				result.wb = 1'b0;
				result.skip = ((b_value & a_value) != 16'h0);
			end
			wae_pkg::MODE_IFE: begin
				result.wb = 1'b0;
				result.skip = (b_value != a_value);
			end
			wae_pkg::MODE_IFN: begin
				result.wb = 1'b0;
				result.skip = (b_value == a_value);
			end
			wae_pkg::MODE_IFG: begin
				result.wb = 1'b0;
				result.skip = !(b_value > a_value);
			end
			wae_pkg::MODE_IFA: begin
				result.wb = 1'b0;
				result.skip = !sgt;
			end
			wae_pkg::MODE_IFL: begin
				result.wb = 1'b0;
				result.skip = !(b_value < a_value);
			end
			wae_pkg::MODE_IFU: begin
				result.wb = 1'b0;
				result.skip = !slt;
			end
			wae_pkg::MODE_ADX: begin
				result.res = adx_t[15:0];
				result.ex = (adx_t[17:16] != 2'd0) ? wae_pkg::EX_CARRY : 16'h0;
			end
			wae_pkg::MODE_SBX: begin
				result.res = sbx_t[15:0];
				if (sbx_t < 0) begin
					result.ex = wae_pkg::EX_BORROW;
				end else if (sbx_t[18:16] != 3'd0) begin
					result.ex = wae_pkg::EX_CARRY;
				end else begin
					result.ex = 16'h0;
				end
			end
			default: begin
				result.wb = 1'b0;
			end
		endcase
	end

endmodule

FILE: rtl/core/wae_div.sv
// Iterative radix-4 restoring divider of a 32-bit dividend by a 16-bit divisor.
// Depends on wae_pkg; gives quotient words for DIV/DVI and the remainder for MOD/MDI.
module wae_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  wae_pkg::div_ctl_t          ctl,
	input  logic [wae_pkg::WORD_W-1:0] a_value,
	input  logic [wae_pkg::WORD_W-1:0] b_value,
	output logic                       busy,
	output logic [wae_pkg::WORD_W-1:0] res_word,
	output logic [wae_pkg::WORD_W-1:0] ex_word
);

	logic                       busy_q;
	logic [wae_pkg::CNT_W-1:0]  cnt_q;
	logic [2*wae_pkg::WORD_W-1:0] dvd_q;
	logic [wae_pkg::WORD_W-1:0] rem_q;
	logic [wae_pkg::WORD_W-1:0] dsr_q;
	logic                       negq_q;
	logic                       negr_q;
	logic                       mod_q;

	logic [wae_pkg::WORD_W-1:0] mag_a;
	logic [wae_pkg::WORD_W-1:0] mag_b;
	logic [wae_pkg::WORD_W:0]   r1;
	logic [wae_pkg::WORD_W:0]   r1s;
	logic [wae_pkg::WORD_W:0]   r2;
	logic [wae_pkg::WORD_W:0]   r2s;
	logic                       ge1;
	logic                       ge2;
	logic [wae_pkg::WORD_W-1:0] q_hi;
	logic [wae_pkg::WORD_W-1:0] q_lo;

	assign mag_a = (ctl.is_signed && a_value[15]) ? (16'h0 - a_value) : a_value;
	assign mag_b = (ctl.is_signed && b_value[15]) ? (16'h0 - b_value) : b_value;

	assign r1 = {rem_q, dvd_q[31]};
	assign ge1 = (r1 >= {1'b0, dsr_q});
	assign r1s = ge1 ? (r1 - {1'b0, dsr_q}) : r1;
	assign r2 = {r1s[15:0], dvd_q[30]};
	assign ge2 = (r2 >= {1'b0, dsr_q});
	assign r2s = ge2 ? (r2 - {1'b0, dsr_q}) : r2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			cnt_q <= ctl.is_mod ? wae_pkg::CNT_W'(wae_pkg::MOD_ITERS - 1)
				: wae_pkg::CNT_W'(wae_pkg::DIV_ITERS - 1);
		end else if (busy_q) begin
			cnt_q <= cnt_q - wae_pkg::CNT_W'(1);
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			dvd_q <= {mag_b, 16'h0};
			rem_q <= '0;
			dsr_q <= mag_a;
			negq_q <= ctl.is_signed && (a_value[15] ^ b_value[15]);
			negr_q <= ctl.is_signed && b_value[15];
			mod_q <= ctl.is_mod;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[29:0], ge1, ge2};
			rem_q <= r2s[15:0];
		end
	end

	assign q_hi = negq_q ? (16'h0 - dvd_q[31:16]) : dvd_q[31:16];
	assign q_lo = negq_q ? (16'h0 - dvd_q[15:0]) : dvd_q[15:0];

	assign busy = busy_q;
	assign res_word = mod_q ? (negr_q ? (16'h0 - rem_q) : rem_q) : q_hi;
	assign ex_word = q_lo;

endmodule

FILE: rtl/core/word_alu_with_excess_register_top.sv
// Word ALU with excess register: executes one basic two-operand instruction per beat.
// Handshake on both sides is valid/ready. Payload ports are the operation fields.
// A beat is accepted on the input when in_valid and in_ready are both high, and
// a result beat leaves when out_valid and out_ready are both high.
// Every accepted instruction gives exactly one result beat.
// Other operations, and divides by zero, reach the output register in the cycle after acceptance.
// DIV, DVI, MOD and MDI with a nonzero divisor go to the shared divider, which
// resolves two quotient bits per cycle.
// While the divider runs, in_ready is low, so one instruction is in flight at a time.
// If the receiver stalls, the result stays in the output register and a new beat is
// taken only in the cycle in which the waiting result is taken.
// Reset clears the excess register to zero, empties the output register and stops
// the divider.
module word_alu_with_excess_register_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [4:0]  mode,
	input  logic [15:0] a_value,
	input  logic [15:0] b_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [15:0] result_word,
	output logic        writes_back,
	output logic        skip_next,
	output logic [15:0] excess_word
);

	`include "word_alu_with_excess_register_top_macros.svh"

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_DIV = 1'b1;

	logic                       state_q;
	logic                       out_valid_q;
	logic [wae_pkg::WORD_W-1:0] ex_q;
	logic                       mod_op_q;
	logic [wae_pkg::WORD_W-1:0] res_q;
	logic                       wb_q;
	logic                       skip_q;
	logic [wae_pkg::WORD_W-1:0] exo_q;

	logic                       slot_free;
	logic                       accept;
	logic                       div_op;
	logic                       div_done;
	logic                       div_busy;
	logic [wae_pkg::WORD_W-1:0] div_res;
	logic [wae_pkg::WORD_W-1:0] div_ex;
	logic [wae_pkg::WORD_W-1:0] div_ex_new;
	wae_pkg::div_ctl_t          div_ctl;
	wae_pkg::alu_res_t          alu_res;

	assign slot_free = !out_valid_q || out_ready;
	assign in_ready = (state_q == ST_IDLE) && slot_free;
	assign accept = in_valid && in_ready;
	assign div_op = (mode == wae_pkg::MODE_DIV) || (mode == wae_pkg::MODE_DVI)
		|| (mode == wae_pkg::MODE_MOD) || (mode == wae_pkg::MODE_MDI);

	assign div_ctl.start = accept && div_op && (a_value != 16'h0);
	assign div_ctl.is_signed = (mode == wae_pkg::MODE_DVI) || (mode == wae_pkg::MODE_MDI);
	assign div_ctl.is_mod = (mode == wae_pkg::MODE_MOD) || (mode == wae_pkg::MODE_MDI);

	assign div_done = (state_q == ST_DIV) && !div_busy && slot_free;
	assign div_ex_new = mod_op_q ? ex_q : div_ex;

	wae_alu u_alu (
		.mode    (mode),
		.a_value (a_value),
		.b_value (b_value),
		.ex_in   (ex_q),
		.result  (alu_res)
	);

	wae_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (div_ctl),
		.a_value  (a_value),
		.b_value  (b_value),
		.busy     (div_busy),
		.res_word (div_res),
		.ex_word  (div_ex)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
			ex_q <= '0;
		end else if (div_ctl.start) begin
			state_q <= ST_DIV;
			if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end else if (accept) begin
			out_valid_q <= 1'b1;
			ex_q <= alu_res.ex;
		end else if (div_done) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b1;
			ex_q <= div_ex_new;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (div_ctl.start) begin
			mod_op_q <= div_ctl.is_mod;
		end
		if (accept && !div_ctl.start) begin
			res_q <= alu_res.res;
			wb_q <= alu_res.wb;
			skip_q <= alu_res.skip;
			exo_q <= alu_res.ex;
		end else if (div_done) begin
			res_q <= div_res;
			wb_q <= 1'b1;
			skip_q <= 1'b0;
			exo_q <= div_ex_new;
		end
	end

	assign out_valid = out_valid_q;
	assign result_word = res_q;
	assign writes_back = wb_q;
	assign skip_next = skip_q;
	assign excess_word = exo_q;

	`WAE_ASSERT_IMP(a_no_accept_in_div, clk, arst_n, div_busy, !in_ready)
	`WAE_ASSERT_NEXT(a_div_starts, clk, arst_n, div_ctl.start, div_busy && (state_q == ST_DIV))
	`WAE_ASSERT_IMP(a_ex_matches_out, clk, arst_n, out_valid_q, exo_q == ex_q)
	`WAE_ASSERT_IMP(a_skip_no_wb, clk, arst_n, out_valid_q && skip_q, !wb_q)

endmodule

FILE: verif/tb_word_alu_with_excess_register_top.sv
// Testbench for word_alu_with_excess_register_top: directed and random instructions
// checked beat by beat against an in-bench model of the ALU and its EX register.
// Depends on wae_pkg and the top level RTL only.
`timescale 1ns / 1ps

module tb_word_alu_with_excess_register_top;

	localparam logic [4:0] MODE_UNUSED_LAST = 5'd31;
	localparam int HOLD_CYCLES = 200;
	localparam int SETTLE_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [4:0]  mode = wae_pkg::MODE_SET;
	logic [15:0] a_value = '0;
	logic [15:0] b_value = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] result_word;
	logic        writes_back;
	logic        skip_next;
	logic [15:0] excess_word;

	wae_pkg::alu_res_t alu_results_due[$];
	wae_pkg::alu_res_t result_want;
	logic [15:0] ex_shadow = '0;
	int          mismatch_count = 0;
	int          send_idle_pct = 0;
	int          recv_idle_pct = 0;
	int          hold_req = 0;
	int          hold_seen = 0;
	int          hold_left = 0;

	word_alu_with_excess_register_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.a_value(a_value),
		.b_value(b_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.result_word(result_word),
		.writes_back(writes_back),
		.skip_next(skip_next),
		.excess_word(excess_word)
	);

	always #1 clk = ~clk;

	function automatic wae_pkg::alu_res_t execute_instr(input logic [4:0] op,
			input logic [15:0] a, input logic [15:0] b, input logic [15:0] ex);
		wae_pkg::alu_res_t r;
		logic [31:0] wide;
		logic [17:0] sum;
		longint      sa;
		longint      sb;
		longint      q;
		longint      t;
		sa = $signed(a);
		sb = $signed(b);
		r.res = b;
		r.wb = 1'b1;
		r.skip = 1'b0;
		r.ex = ex;
		case (op)
			wae_pkg::MODE_SET: r.res = a;
			wae_pkg::MODE_ADD: begin
				sum = b + a;
				r.res = sum[15:0];
				r.ex = sum[16] ? wae_pkg::EX_CARRY : '0;
			end
			wae_pkg::MODE_SUB: begin
				r.res = b - a;
				r.ex = (a > b) ? wae_pkg::EX_BORROW : '0;
			end
			wae_pkg::MODE_MUL: begin
				wide = b * a;
				r.res = wide[15:0];
				r.ex = wide[31:16];
			end
			wae_pkg::MODE_MLI: begin
				t = sb * sa;
				r.res = t[15:0];
				r.ex = t[31:16];
			end
			wae_pkg::MODE_DIV: begin
				if (a == '0) begin
					r.res = '0;
					r.ex = '0;
				end else begin
					r.res = b / a;
					wide = {b, 16'h0000} / a;
					r.ex = wide[15:0];
				end
			end
			wae_pkg::MODE_DVI: begin
				if (a == '0) begin
					r.res = '0;
					r.ex = '0;
				end else begin
					q = sb / sa;
					t = (sb * 65536) / sa;
					r.res = q[15:0];
					r.ex = t[15:0];
				end
			end
			wae_pkg::MODE_MOD: begin
				if (a == '0) begin
					r.res = '0;
					r.ex = '0;
				end else begin
					r.res = b % a;
				end
			end
			wae_pkg::MODE_MDI: begin
				if (a == '0) begin
					r.res = '0;
					r.ex = '0;
				end else begin
					q = sb % sa;
					r.res = q[15:0];
				end
			end
			wae_pkg::MODE_AND: r.res = b & a;
			wae_pkg::MODE_BOR: r.res = b | a;
			wae_pkg::MODE_XOR: r.res = b ^ a;
			wae_pkg::MODE_SHR, wae_pkg::MODE_ASR: begin
				wide = (a >= 16'd32) ? 32'h0 : ({b, 16'h0000} >> a[4:0]);
				r.ex = wide[15:0];
				if (op == wae_pkg::MODE_SHR)
					r.res = (a >= 16'd16) ? 16'h0000 : (b >> a[3:0]);
				else
					r.res = (a >= 16'd16) ? {16{b[15]}} : 16'($signed(b) >>> a[3:0]);
			end
			wae_pkg::MODE_SHL: begin
				wide = (a >= 16'd32) ? 32'h0 : ({16'h0000, b} << a[4:0]);
				r.res = wide[15:0];
				r.ex = wide[31:16];
			end
			wae_pkg::MODE_IFB: r.skip = ((b & a) == '0);
			wae_pkg::MODE_IFC: r.skip = ((b & a) != '0);
			wae_pkg::MODE_IFE: r.skip = (b != a);
			wae_pkg::MODE_IFN: r.skip = (b == a);
			wae_pkg::MODE_IFG: r.skip = !(b > a);
			wae_pkg::MODE_IFA: r.skip = !(sb > sa);
			wae_pkg::MODE_IFL: r.skip = !(b < a);
			wae_pkg::MODE_IFU: r.skip = !(sb < sa);
			wae_pkg::MODE_ADX: begin
				sum = b + a + ex;
				r.res = sum[15:0];
				r.ex = (sum > 18'h0ffff) ? wae_pkg::EX_CARRY : '0;
			end
			wae_pkg::MODE_SBX: begin
				t = longint'(b) - longint'(a) + longint'(ex);
				r.res = t[15:0];
				if (t < 0)
					r.ex = wae_pkg::EX_BORROW;
				else if (t > 65535)
					r.ex = wae_pkg::EX_CARRY;
				else
					r.ex = '0;
			end
			default: r.wb = 1'b0;
		endcase
		if (op >= wae_pkg::MODE_IFB && op <= wae_pkg::MODE_IFU)
			r.wb = 1'b0;
		return r;
	endfunction

	task automatic send_instr(input logic [4:0] op, input logic [15:0] a, input logic [15:0] b);
		if ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= op;
		a_value <= a;
		b_value <= b;
		do
			@(negedge clk);
		while (!in_ready);
		@(posedge clk);
		alu_results_due.push_back(execute_instr(op, a, b, ex_shadow));
		ex_shadow = alu_results_due[$].ex;
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (alu_results_due.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [15:0] pick_operand();
		case ($urandom_range(9))
			0: return 16'h0000;
			1: return 16'hffff;
			2: return 16'h8000;
			3: return 16'h7fff;
			4: return 16'h0001;
			5: return 16'($urandom_range(40));
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic send_random_instr();
		logic [4:0]  op;
		logic [15:0] a;
		if ($urandom_range(99) < 8)
			op = 5'($urandom_range(MODE_UNUSED_LAST, wae_pkg::MODE_SBX + 1));
		else
			op = 5'($urandom_range(wae_pkg::MODE_SBX, wae_pkg::MODE_SET));
		a = pick_operand();
		if ((op == wae_pkg::MODE_SHR || op == wae_pkg::MODE_ASR
				|| op == wae_pkg::MODE_SHL) && $urandom_range(3) != 0)
			a = 16'($urandom_range(40));
		send_instr(op, a, pick_operand());
	endtask

	task automatic test_add_sub_excess();
		send_instr(wae_pkg::MODE_SET, 16'hffff, 16'h0000);
		send_instr(wae_pkg::MODE_ADD, 16'h0001, 16'hffff);
		send_instr(wae_pkg::MODE_ADX, 16'hffff, 16'hffff);
		send_instr(wae_pkg::MODE_SUB, 16'h0001, 16'h0000);
		send_instr(wae_pkg::MODE_SBX, 16'h0000, 16'hffff);
		send_instr(wae_pkg::MODE_SBX, 16'hffff, 16'h0000);
		send_instr(wae_pkg::MODE_MUL, 16'hffff, 16'hffff);
		send_instr(wae_pkg::MODE_MLI, 16'hffff, 16'h8000);
	endtask

	task automatic test_divide_modulo();
		send_instr(wae_pkg::MODE_DIV, 16'h0000, 16'hffff);
		send_instr(wae_pkg::MODE_DIV, 16'h0003, 16'hffff);
		send_instr(wae_pkg::MODE_DVI, 16'hffff, 16'h8000);
		send_instr(wae_pkg::MODE_DVI, 16'h0000, 16'h8000);
		send_instr(wae_pkg::MODE_MOD, 16'h0000, 16'h1234);
		send_instr(wae_pkg::MODE_MDI, 16'h0003, 16'hfff9);
		send_instr(wae_pkg::MODE_MDI, 16'h0000, 16'hfff9);
	endtask

	task automatic test_logic_shift();
		send_instr(wae_pkg::MODE_AND, 16'haaaa, 16'hffff);
		send_instr(wae_pkg::MODE_BOR, 16'h5555, 16'haaaa);
		send_instr(wae_pkg::MODE_XOR, 16'hffff, 16'hffff);
		send_instr(wae_pkg::MODE_SHR, 16'h0020, 16'hffff);
		send_instr(wae_pkg::MODE_ASR, 16'h0010, 16'h8000);
		send_instr(wae_pkg::MODE_SHL, 16'h001f, 16'hffff);
	endtask

	task automatic test_conditionals();
		for (int m = wae_pkg::MODE_IFB; m <= wae_pkg::MODE_IFU; m++)
			send_instr(5'(m), 16'h8000, 16'h7fff);
		send_instr(MODE_UNUSED_LAST, 16'hffff, 16'h8001);
	endtask

	task automatic test_random_traffic(input int count);
		repeat (count)
			send_random_instr();
	endtask

	// The receiver stops taking results while the sender keeps offering instructions,
	// so the output register fills and in_ready must fall.
	task automatic test_backpressure();
		hold_req++;
		repeat (30)
			send_random_instr();
		wait_all_results();
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else if (hold_req != hold_seen) begin
			hold_seen = hold_req;
			hold_left = HOLD_CYCLES - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	task automatic compare_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (alu_results_due.size() == 0) begin
				$display("%0t: unexpected result beat, actual result_word %h", $time,
					result_word);
				mismatch_count++;
			end else begin
				result_want = alu_results_due.pop_front();
				compare_field("result_word", result_want.res, result_word);
				compare_field("writes_back", 16'(result_want.wb), 16'(writes_back));
				compare_field("skip_next", 16'(result_want.skip), 16'(skip_next));
				compare_field("excess_word", result_want.ex, excess_word);
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		send_idle_pct = 38;
		recv_idle_pct = 38;
		test_add_sub_excess();
		test_divide_modulo();
		test_logic_shift();
		test_conditionals();
		test_random_traffic(600);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_traffic(300);
		test_backpressure();
		send_idle_pct = 38;
		recv_idle_pct = 38;
		test_random_traffic(560);
		wait_all_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && alu_results_due.size() == 0)
			$display("[word_alu_with_excess_register_top] OK");
		else
			$display("[word_alu_with_excess_register_top] ERROR");
		$finish;
	end

	initial begin
		#400000;
		$display("[word_alu_with_excess_register_top] ERROR");
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl/core
rtl/core/wae_pkg.sv
rtl/core/wae_alu.sv
rtl/core/wae_div.sv
rtl/core/word_alu_with_excess_register_top.sv
verif/tb_word_alu_with_excess_register_top.sv
